// File: hw/rtl/tft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tft_pkg;

    // field widths
    localparam int TFT_IDX_W      = 24;
    localparam int TFT_DATA_W     = 32;
    localparam int TFT_WIDE_W     = 64;
    localparam int TFT_INDEX_BITS = 24;

    // one corner as it arrives
    typedef struct packed {
        logic        [TFT_IDX_W-1:0]  vertex_index;
        logic signed [TFT_DATA_W-1:0] pos_x;
        logic signed [TFT_DATA_W-1:0] pos_y;
        logic signed [TFT_DATA_W-1:0] pos_z;
        logic signed [TFT_DATA_W-1:0] tex_u;
        logic signed [TFT_DATA_W-1:0] tex_v;
    } tft_in_t;

    // one per-vertex tangent result
    typedef struct packed {
        logic        [TFT_IDX_W-1:0]  out_vertex_index;
        logic signed [TFT_DATA_W-1:0] tangent_x;
        logic signed [TFT_DATA_W-1:0] tangent_y;
        logic signed [TFT_DATA_W-1:0] tangent_z;
        logic                         degenerate;
        logic                         last_of_triangle;
    } tft_out_t;

    // held corner geometry, index kept apart
    typedef struct packed {
        logic signed [TFT_DATA_W-1:0] x;
        logic signed [TFT_DATA_W-1:0] y;
        logic signed [TFT_DATA_W-1:0] z;
        logic signed [TFT_DATA_W-1:0] u;
        logic signed [TFT_DATA_W-1:0] v;
    } tft_corner_t;

    // per-triangle result of the compute core
    typedef struct packed {
        logic signed [TFT_DATA_W-1:0] tangent_x;
        logic signed [TFT_DATA_W-1:0] tangent_y;
        logic signed [TFT_DATA_W-1:0] tangent_z;
        logic                         degenerate;
    } tft_res_t;

    // core status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } tft_core_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tft_qdiv.sv
`timescale 1ns / 1ps
`default_nettype none

// n * 2^16 / d, truncated toward zero, saturated to signed Q16.16, one bit per cycle
module tft_qdiv
    import tft_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [TFT_WIDE_W-1:0] num,
    input  wire logic signed [TFT_WIDE_W-1:0] den,
    output logic                              done,
    output logic signed [TFT_DATA_W-1:0]      quot
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FIN
    } state_t;

    state_t                  state_reg;
    logic [4:0]              cnt_reg;
    logic                    done_reg;
    logic [TFT_WIDE_W-1:0]   a_reg;
    logic [TFT_WIDE_W-1:0]   b_reg;
    logic [TFT_WIDE_W-1:0]   rem_reg;
    logic [TFT_DATA_W-1:0]   q_reg;
    logic                    neg_reg;
    logic                    ovf_reg;
    logic [TFT_DATA_W-1:0]   quot_reg;

    logic [TFT_WIDE_W-1:0]   num_mag;
    logic [TFT_WIDE_W-1:0]   den_mag;
    logic [15:0]             a_low;
    logic                    in_bit;
    logic [TFT_WIDE_W:0]     trial;
    logic [TFT_WIDE_W+1:0]   diff;
    logic                    ovf_now;
    logic [TFT_DATA_W:0]     q_mag;
    logic [TFT_DATA_W:0]     q_neg;
    logic [TFT_DATA_W-1:0]   q_sat;

    // operand magnitudes
    assign num_mag = num[TFT_WIDE_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[TFT_WIDE_W-1] ? (~den + 1'b1) : den;

    // integer part of the quotient must stay below 2^16
    assign ovf_now = {16'd0, a_reg[TFT_WIDE_W-1:16]} >= b_reg;

    // restoring step: fraction bits of the shifted dividend come in as zeros
    assign a_low  = a_reg[15:0];
    assign in_bit = cnt_reg[4] & a_low[cnt_reg[3:0]];
    assign trial  = {rem_reg, in_bit};
    assign diff   = {1'b0, trial} - {2'b00, b_reg};

    // sign and saturate
    assign q_mag = ovf_reg ? {1'b1, {TFT_DATA_W{1'b0}}} : {1'b0, q_reg};
    assign q_neg = ~q_mag + 1'b1;
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_mag > {2'b01, {(TFT_DATA_W-1){1'b0}}})
                q_sat = {1'b1, {(TFT_DATA_W-1){1'b0}}};
            else
                q_sat = q_neg[TFT_DATA_W-1:0];
        end
        else
        begin
            if (q_mag > {2'b00, {(TFT_DATA_W-1){1'b1}}})
                q_sat = {1'b0, {(TFT_DATA_W-1){1'b1}}};
            else
                q_sat = q_mag[TFT_DATA_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    cnt_reg   <= 5'd31;
                    state_reg <= ovf_now ? S_FIN : S_RUN;
                end
                S_RUN:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_reg   <= num_mag;
                    b_reg   <= den_mag;
                    neg_reg <= num[TFT_WIDE_W-1] ^ den[TFT_WIDE_W-1];
                end
            end
            S_PREP:
            begin
                ovf_reg <= ovf_now;
                rem_reg <= {16'd0, a_reg[TFT_WIDE_W-1:16]};
                q_reg   <= '0;
            end
            S_RUN:
            begin
                if (!diff[TFT_WIDE_W+1])
                begin
                    rem_reg <= diff[TFT_WIDE_W-1:0];
                    q_reg   <= {q_reg[TFT_DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[TFT_WIDE_W-1:0];
                    q_reg   <= {q_reg[TFT_DATA_W-2:0], 1'b0};
                end
            end
            S_FIN:
            begin
                quot_reg <= q_sat;
            end
            default:
            begin
                quot_reg <= quot_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tft_core.sv
`timescale 1ns / 1ps
`default_nettype none

// tangent sequencer: shared saturating subtractor, shared multiplier, iterative divider
module tft_core
    import tft_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tft_corner_t      c0,
    input  wire tft_corner_t      c1,
    input  wire tft_corner_t      c2,
    output tft_core_status_t      status,
    output tft_res_t              res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_MUL,
        S_DIV,
        S_DIVW,
        S_DONE
    } state_t;

    // delta slots
    localparam logic [3:0] D_E1X = 4'd0;
    localparam logic [3:0] D_E1Y = 4'd1;
    localparam logic [3:0] D_E1Z = 4'd2;
    localparam logic [3:0] D_E2X = 4'd3;
    localparam logic [3:0] D_E2Y = 4'd4;
    localparam logic [3:0] D_E2Z = 4'd5;
    localparam logic [3:0] D_DU1 = 4'd6;
    localparam logic [3:0] D_DV1 = 4'd7;
    localparam logic [3:0] D_DU2 = 4'd8;
    localparam logic [3:0] D_DV2 = 4'd9;
    localparam logic [3:0] D_LAST  = D_DV2;
    localparam logic [3:0] M_LAST  = 4'd8;
    localparam logic [1:0] K_LAST  = 2'd2;

    state_t                        state_reg;
    logic [3:0]                    dstep_reg;
    logic [3:0]                    mstep_reg;
    logic [1:0]                    k_reg;
    logic                          done_reg;

    logic signed [TFT_DATA_W-1:0]  delta_reg [0:9];
    logic signed [TFT_WIDE_W-1:0]  prod_reg;
    logic signed [TFT_WIDE_W-1:0]  acc_reg;
    logic signed [TFT_WIDE_W-1:0]  wide_reg [0:3];
    logic signed [TFT_DATA_W-1:0]  tan_reg  [0:2];
    logic                          degen_reg;

    logic signed [TFT_DATA_W-1:0]  sa;
    logic signed [TFT_DATA_W-1:0]  sb;
    logic signed [TFT_DATA_W:0]    sdiff;
    logic signed [TFT_DATA_W-1:0]  ssat;
    logic signed [TFT_DATA_W-1:0]  ma;
    logic signed [TFT_DATA_W-1:0]  mb;
    logic signed [TFT_WIDE_W-1:0]  mprod;
    logic [3:0]                    mprev;
    logic [1:0]                    num_sel;
    logic                          det_zero;
    logic                          div_start;
    logic                          div_done;
    logic signed [TFT_DATA_W-1:0]  div_quot;

    // subtractor operands by step
    always_comb
    begin
        case (dstep_reg)
            D_E1X:   begin sa = c1.x; sb = c0.x; end
            D_E1Y:   begin sa = c1.y; sb = c0.y; end
            D_E1Z:   begin sa = c1.z; sb = c0.z; end
            D_E2X:   begin sa = c2.x; sb = c0.x; end
            D_E2Y:   begin sa = c2.y; sb = c0.y; end
            D_E2Z:   begin sa = c2.z; sb = c0.z; end
            D_DU1:   begin sa = c1.u; sb = c0.u; end
            D_DV1:   begin sa = c1.v; sb = c0.v; end
            D_DU2:   begin sa = c2.u; sb = c0.u; end
            D_DV2:   begin sa = c2.v; sb = c0.v; end
            default: begin sa = '0;   sb = '0;   end
        endcase
    end

    // saturating subtract
    assign sdiff = {sa[TFT_DATA_W-1], sa} - {sb[TFT_DATA_W-1], sb};
    always_comb
    begin
        if (sdiff[TFT_DATA_W] != sdiff[TFT_DATA_W-1])
            ssat = sdiff[TFT_DATA_W] ? {1'b1, {(TFT_DATA_W-1){1'b0}}}
                                     : {1'b0, {(TFT_DATA_W-1){1'b1}}};
        else
            ssat = sdiff[TFT_DATA_W-1:0];
    end

    // multiplier operands: det terms first, then the three numerators
    always_comb
    begin
        case (mstep_reg)
            4'd0:    begin ma = delta_reg[D_DU1]; mb = delta_reg[D_DV2]; end
            4'd1:    begin ma = delta_reg[D_DU2]; mb = delta_reg[D_DV1]; end
            4'd2:    begin ma = delta_reg[D_DV2]; mb = delta_reg[D_E1X]; end
            4'd3:    begin ma = delta_reg[D_DV1]; mb = delta_reg[D_E2X]; end
            4'd4:    begin ma = delta_reg[D_DV2]; mb = delta_reg[D_E1Y]; end
            4'd5:    begin ma = delta_reg[D_DV1]; mb = delta_reg[D_E2Y]; end
            4'd6:    begin ma = delta_reg[D_DV2]; mb = delta_reg[D_E1Z]; end
            4'd7:    begin ma = delta_reg[D_DV1]; mb = delta_reg[D_E2Z]; end
            default: begin ma = '0;               mb = '0;               end
        endcase
    end

    assign mprod     = ma * mb;
    assign mprev     = mstep_reg - 4'd1;
    assign det_zero  = (wide_reg[0] == '0);
    assign num_sel   = k_reg + 2'd1;
    assign div_start = (state_reg == S_DIV) && !det_zero;

    tft_qdiv u_qdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (wide_reg[num_sel]),
        .den   (wide_reg[0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dstep_reg <= '0;
            mstep_reg <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        dstep_reg <= '0;
                        state_reg <= S_DELTA;
                    end
                end
                S_DELTA:
                begin
                    dstep_reg <= dstep_reg + 4'd1;
                    if (dstep_reg == D_LAST)
                    begin
                        mstep_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 4'd1;
                    if (mstep_reg == M_LAST)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (det_zero)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == K_LAST)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DELTA)
            delta_reg[dstep_reg] <= ssat;

        if (state_reg == S_MUL)
        begin
            prod_reg <= mprod;
            if (mstep_reg != 4'd0)
            begin
                if (!mprev[0])
                    acc_reg <= prod_reg;
                else
                    wide_reg[mprev[2:1]] <= acc_reg - prod_reg;
            end
        end

        if (state_reg == S_DIV && det_zero)
        begin
            tan_reg[0] <= '0;
            tan_reg[1] <= '0;
            tan_reg[2] <= '0;
            degen_reg  <= 1'b1;
        end
        else if (state_reg == S_DIVW && div_done)
        begin
            tan_reg[k_reg] <= div_quot;
            degen_reg      <= 1'b0;
        end
    end

    assign status.busy    = (state_reg != S_IDLE);
    assign status.done    = done_reg;
    assign res.tangent_x  = tan_reg[0];
    assign res.tangent_y  = tan_reg[1];
    assign res.tangent_z  = tan_reg[2];
    assign res.degenerate = degen_reg;

endmodule

`default_nettype wire

// File: hw/rtl/triangle_tangent_from_uv.sv
// Per-triangle tangent from position and texture-coordinate deltas, signed Q16.16.
// Input channel corner_valid/corner_ready/corner: one triangle corner per transaction,
// three corners make a triangle. Output channel result_valid/result_ready/result:
// three transactions per triangle, one per corner in arrival order, all with the
// same tangent, the third flagged last_of_triangle.
// The first two corners of a triangle are only stored. The third
// starts the compute core, which runs 10 subtract steps, 9 multiply steps and
// three divisions (one quotient bit per cycle in the shared divider). A zero
// determinant skips the divisions, and a quotient whose integer part
// saturates skips the bit-serial steps of its division.
// corner_ready is low while the core runs. Results sit in an output buffer: the
// first two corners of the next triangle are still taken while the receiver
// stalls, its third corner waits until all three results have been taken.
// A zero UV determinant gives a zero tangent with degenerate set; all other
// overflow saturates. Reset clears the corner count and the output buffer;
// the held corner registers keep no reset value.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_from_uv
    import tft_pkg::*;
#(
    parameter int INDEX_BITS = TFT_INDEX_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     corner_valid,
    output logic          corner_ready,
    input  wire tft_in_t  corner,
    output logic          result_valid,
    input  wire logic     result_ready,
    output tft_out_t      result
);

    localparam int         HELD_W   = (INDEX_BITS < TFT_IDX_W) ? INDEX_BITS : TFT_IDX_W;
    localparam logic [1:0] CNT_ZERO = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_OOR  = 2'd3;
    localparam logic [1:0] SEL_LAST = 2'd2;

    logic [1:0]          count_reg;
    logic                start_reg;
    logic                pending_reg;
    logic [1:0]          sel_reg;

    tft_corner_t         c0_reg;
    tft_corner_t         c1_reg;
    tft_corner_t         c2_reg;
    logic [HELD_W-1:0]   idx0_reg;
    logic [HELD_W-1:0]   idx1_reg;
    logic [HELD_W-1:0]   idx2_reg;
    logic [HELD_W-1:0]   out_idx_reg [0:2];

    logic [1:0]          count_eff;
    logic                in_fire;
    logic                out_fire;
    logic                third;
    tft_corner_t         cin;
    logic [HELD_W-1:0]   idx_in;
    logic [HELD_W-1:0]   idx_sel;
    tft_core_status_t    core_st;
    tft_res_t            core_res;

    // counter value three behaves as zero
    assign count_eff = (count_reg == CNT_OOR) ? CNT_ZERO : count_reg;
    assign third     = (count_eff == CNT_TWO);

    // no corner while the core is starting or running, no third corner while results wait
    assign corner_ready = !core_st.busy && !start_reg && !(third && pending_reg);
    assign in_fire      = corner_valid && corner_ready;
    assign out_fire     = result_valid && result_ready;

    assign cin.x  = corner.pos_x;
    assign cin.y  = corner.pos_y;
    assign cin.z  = corner.pos_z;
    assign cin.u  = corner.tex_u;
    assign cin.v  = corner.tex_v;
    assign idx_in = corner.vertex_index[HELD_W-1:0];

    tft_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .c0     (c0_reg),
        .c1     (c1_reg),
        .c2     (c2_reg),
        .status (core_st),
        .res    (core_res)
    );

    // corner count, core start, output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CNT_ZERO;
            start_reg   <= 1'b0;
            pending_reg <= 1'b0;
            sel_reg     <= '0;
        end
        else
        begin
            start_reg <= in_fire && third;
            if (in_fire)
            begin
                case (count_eff)
                    CNT_ZERO: count_reg <= CNT_ONE;
                    CNT_ONE:  count_reg <= CNT_TWO;
                    default:  count_reg <= CNT_ZERO;
                endcase
            end

            if (core_st.done)
            begin
                pending_reg <= 1'b1;
                sel_reg     <= '0;
            end
            else if (out_fire)
            begin
                if (sel_reg == SEL_LAST)
                    pending_reg <= 1'b0;
                else
                    sel_reg <= sel_reg + 2'd1;
            end
        end
    end

    // held corners and result indices
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            case (count_eff)
                CNT_ZERO:
                begin
                    c0_reg   <= cin;
                    idx0_reg <= idx_in;
                end
                CNT_ONE:
                begin
                    c1_reg   <= cin;
                    idx1_reg <= idx_in;
                end
                default:
                begin
                    c2_reg   <= cin;
                    idx2_reg <= idx_in;
                end
            endcase
        end
        if (core_st.done)
        begin
            out_idx_reg[0] <= idx0_reg;
            out_idx_reg[1] <= idx1_reg;
            out_idx_reg[2] <= idx2_reg;
        end
    end

    // output transaction
    always_comb
    begin
        case (sel_reg)
            2'd0:    idx_sel = out_idx_reg[0];
            2'd1:    idx_sel = out_idx_reg[1];
            default: idx_sel = out_idx_reg[2];
        endcase
    end

    assign result_valid            = pending_reg;
    assign result.out_vertex_index = TFT_IDX_W'(idx_sel);
    assign result.tangent_x        = core_res.tangent_x;
    assign result.tangent_y        = core_res.tangent_y;
    assign result.tangent_z        = core_res.tangent_z;
    assign result.degenerate       = core_res.degenerate;
    assign result.last_of_triangle = (sel_reg == SEL_LAST);

    // no corner taken while the core owns the held corners
    assert property (@(posedge clk) disable iff (!rst_n)
        (core_st.busy || start_reg) |-> !corner_ready)
        else $error("corner accepted while core busy");

    // buffered results never overlap a running core
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> !core_st.busy)
        else $error("results pending while core busy");

    // a finished triangle opens the buffer at its first corner
    assert property (@(posedge clk) disable iff (!rst_n)
        core_st.done |=> (result_valid && sel_reg == 2'd0))
        else $error("core result not presented");

    // the last result closes the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && sel_reg == SEL_LAST) |=> !result_valid)
        else $error("results continue after last of triangle");

endmodule

`default_nettype wire

// File: dv/tb_triangle_tangent_from_uv.sv
`timescale 1ns / 1ps

module tb_triangle_tangent_from_uv
    import tft_pkg::*;
();

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int RAND_TRIANGLES = 96;
    localparam int DRAIN_CYCLES   = 160;
    localparam int CYCLE_LIMIT    = 400000;
    localparam logic [31:0] ONE   = 32'h0001_0000;
    localparam logic [31:0] QMAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] QMIN  = 32'h8000_0000;

    typedef enum int {TRI_SMALL, TRI_FULL, TRI_DEGEN, TRI_MIXED} tri_kind_t;
    typedef enum int {VAL_SMALL, VAL_MEDIUM, VAL_FULL, VAL_EDGE} val_kind_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     corner_valid = 1'b0;
    logic     corner_ready;
    tft_in_t  corner = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    tft_out_t result;

    // stimulus and scoreboard storage
    tft_in_t  corner_queue[$];
    tft_out_t tangent_expect[$];
    tft_in_t  held_corner[2];
    int       corners_held = 0;
    int       mismatches = 0;
    int       cycle_count = 0;
    int       corner_gap = 0;
    int       corner_draws = 0;
    int       result_stall = 0;
    int       result_draws = 0;

    triangle_tangent_from_uv dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_ready (corner_ready),
        .corner       (corner),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    always #(CLK_HALF) clk = ~clk;

    // append to the pending corner queue
    function automatic void queue_corner(tft_in_t c);
        corner_queue.insert(corner_queue.size(), c);
    endfunction

    // append to the expected result queue
    function automatic void queue_expect(tft_out_t r);
        tangent_expect.insert(tangent_expect.size(), r);
    endfunction

    // wait draw, with stretches of no idling
    function automatic int pick_wait(int draws);
        if ((draws / 40) % 3 == 1)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // difference of two q16.16 values, saturated to 32 bits
    function automatic longint sat_diff(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > longint'(32'sh7FFF_FFFF))
            d = longint'(32'sh7FFF_FFFF);
        else if (d < -longint'(64'h8000_0000))
            d = -longint'(64'h8000_0000);
        return d;
    endfunction

    // n * 2^16 / d, truncated toward zero, saturated to q16.16
    function automatic logic [31:0] scaled_quotient(longint n, longint d);
        bit [127:0] num_mag;
        bit [127:0] den_mag;
        bit [127:0] quot;
        bit         negative;
        negative = (n < 0) != (d < 0);
        num_mag  = (n < 0) ? 128'(-n) : 128'(n);
        den_mag  = (d < 0) ? 128'(-d) : 128'(d);
        quot     = (num_mag << 16) / den_mag;
        if (negative)
        begin
            if (quot > 128'h8000_0000)
                quot = 128'h8000_0000;
            quot = 128'd0 - quot;
        end
        else if (quot > 128'h7FFF_FFFF)
        begin
            quot = 128'h7FFF_FFFF;
        end
        return quot[31:0];
    endfunction

    // hold two corners, on the third queue three tangent results
    function automatic void predict_corner(tft_in_t c);
        longint   e1[3];
        longint   e2[3];
        longint   du1, dv1, du2, dv2, det, numer;
        tft_out_t res;
        logic [31:0] tan[3];
        logic [TFT_IDX_W-1:0] ids[3];
        if (corners_held < 2)
        begin
            held_corner[corners_held] = c;
            corners_held++;
            return;
        end
        e1[0] = sat_diff(held_corner[1].pos_x, held_corner[0].pos_x);
        e1[1] = sat_diff(held_corner[1].pos_y, held_corner[0].pos_y);
        e1[2] = sat_diff(held_corner[1].pos_z, held_corner[0].pos_z);
        e2[0] = sat_diff(c.pos_x, held_corner[0].pos_x);
        e2[1] = sat_diff(c.pos_y, held_corner[0].pos_y);
        e2[2] = sat_diff(c.pos_z, held_corner[0].pos_z);
        du1 = sat_diff(held_corner[1].tex_u, held_corner[0].tex_u);
        dv1 = sat_diff(held_corner[1].tex_v, held_corner[0].tex_v);
        du2 = sat_diff(c.tex_u, held_corner[0].tex_u);
        dv2 = sat_diff(c.tex_v, held_corner[0].tex_v);
        det = du1 * dv2 - du2 * dv1;
        for (int k = 0; k < 3; k++)
        begin
            numer  = dv2 * e1[k] - dv1 * e2[k];
            tan[k] = (det == 0) ? 32'd0 : scaled_quotient(numer, det);
        end
        ids[0] = held_corner[0].vertex_index;
        ids[1] = held_corner[1].vertex_index;
        ids[2] = c.vertex_index;
        for (int j = 0; j < 3; j++)
        begin
            res.out_vertex_index = ids[j];
            res.tangent_x        = tan[0];
            res.tangent_y        = tan[1];
            res.tangent_z        = tan[2];
            res.degenerate       = (det == 0);
            res.last_of_triangle = (j == 2);
            queue_expect(res);
        end
        corners_held = 0;
    endfunction

    function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv)
        begin
            $error("%s: expected %h, got %h", name, expv, actv);
            mismatches++;
        end
    endfunction

    function automatic tft_in_t make_corner(logic [23:0] idx, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [31:0] u, logic [31:0] v);
        tft_in_t c;
        c.vertex_index = idx;
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.tex_u = u;
        c.tex_v = v;
        return c;
    endfunction

    function automatic logic [31:0] pick_value(val_kind_t kind);
        case (kind)
            VAL_SMALL:  return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            VAL_MEDIUM: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            VAL_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       return QMAX;
                    1:       return QMIN;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0;
                endcase
            end
            default:    return $urandom;
        endcase
    endfunction

    function automatic val_kind_t random_val_kind();
        return val_kind_t'($urandom_range(0, 3));
    endfunction

    function automatic logic [23:0] pick_index();
        return 24'($urandom);
    endfunction

    // one random triangle of the given kind
    function automatic void queue_random_triangle(tri_kind_t kind);
        val_kind_t   vk;
        logic [31:0] u0, v0, du, dv;
        vk = (kind == TRI_FULL) ? VAL_FULL : VAL_SMALL;
        if (kind == TRI_DEGEN)
        begin
            // uv corners collinear or coincident, positions random
            u0 = pick_value(VAL_SMALL);
            v0 = pick_value(VAL_SMALL);
            du = $urandom_range(0, 1) ? pick_value(VAL_SMALL) : 32'd0;
            dv = (du == 0) ? 32'd0 : pick_value(VAL_SMALL);
            queue_corner(make_corner(pick_index(), pick_value(VAL_MEDIUM),
                pick_value(VAL_MEDIUM), pick_value(VAL_MEDIUM), u0, v0));
            queue_corner(make_corner(pick_index(), pick_value(VAL_MEDIUM),
                pick_value(VAL_MEDIUM), pick_value(VAL_MEDIUM), u0 + du, v0 + dv));
            queue_corner(make_corner(pick_index(), pick_value(VAL_MEDIUM),
                pick_value(VAL_MEDIUM), pick_value(VAL_MEDIUM), u0 + 2 * du, v0 + 2 * dv));
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (kind == TRI_MIXED)
                queue_corner(make_corner(pick_index(),
                    pick_value(random_val_kind()), pick_value(random_val_kind()),
                    pick_value(random_val_kind()), pick_value(random_val_kind()),
                    pick_value(random_val_kind())));
            else
                queue_corner(make_corner(pick_index(), pick_value(vk),
                    pick_value(vk), pick_value(vk), pick_value(vk), pick_value(vk)));
        end
    endfunction

    // corner driver
    always @(posedge clk)
    begin
        logic    next_valid;
        tft_in_t next_corner;
        if (!rst_n)
        begin
            corner_valid <= 1'b0;
        end
        else
        begin
            next_valid  = corner_valid;
            next_corner = corner;
            if (corner_valid && corner_ready)
            begin
                predict_corner(corner);
                next_valid = 1'b0;
                corner_gap = pick_wait(corner_draws);
                corner_draws++;
            end
            if (!next_valid)
            begin
                if (corner_gap > 0)
                begin
                    corner_gap--;
                end
                else if (corner_queue.size() > 0)
                begin
                    next_corner = corner_queue.pop_front();
                    next_valid  = 1'b1;
                end
            end
            corner_valid <= next_valid;
            corner       <= next_corner;
        end
    end

    // result monitor and ready generation
    always @(posedge clk)
    begin
        logic     next_ready;
        tft_out_t expected;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            next_ready = result_ready;
            if (result_valid && result_ready)
            begin
                if (tangent_expect.size() == 0)
                begin
                    $error("result transaction with no expectation: %h", result);
                    mismatches++;
                end
                else
                begin
                    expected = tangent_expect.pop_front();
                    check_field("out_vertex_index", 32'(expected.out_vertex_index),
                                32'(result.out_vertex_index));
                    check_field("tangent_x", expected.tangent_x, result.tangent_x);
                    check_field("tangent_y", expected.tangent_y, result.tangent_y);
                    check_field("tangent_z", expected.tangent_z, result.tangent_z);
                    check_field("degenerate", 32'(expected.degenerate), 32'(result.degenerate));
                    check_field("last_of_triangle", 32'(expected.last_of_triangle),
                                32'(result.last_of_triangle));
                end
                result_stall = pick_wait(result_draws);
                result_draws++;
                next_ready = 1'b0;
            end
            if (!next_ready)
            begin
                if (result_stall > 0)
                    result_stall--;
                else
                    next_ready = 1'b1;
            end
            result_ready <= next_ready;
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // unit tangent along x
        queue_corner(make_corner(24'h000000, 0, 0, 0, 0, 0));
        queue_corner(make_corner(24'h000001, ONE, 0, 0, ONE, 0));
        queue_corner(make_corner(24'h000002, 0, ONE, 0, 0, ONE));
        // zero determinant, all uv equal, index extremes
        queue_corner(make_corner(24'hFFFFFF, ONE, 2 * ONE, 3 * ONE, 5 * ONE, -3 * ONE));
        queue_corner(make_corner(24'h000000, -ONE, 0, 7 * ONE, 5 * ONE, -3 * ONE));
        queue_corner(make_corner(24'hFFFFFF, 4 * ONE, ONE, 0, 5 * ONE, -3 * ONE));
        // mirrored uv, tangent opposite to the first edge
        queue_corner(make_corner(24'h000010, 0, 0, 0, 0, 0));
        queue_corner(make_corner(24'h000011, ONE, 2 * ONE, -3 * ONE, -ONE, 0));
        queue_corner(make_corner(24'h000012, 0, ONE, 0, 0, ONE));
        // tiny determinant, tangent saturates both ways
        queue_corner(make_corner(24'h000020, 0, 0, 0, 0, 0));
        queue_corner(make_corner(24'h000021, 32'h4000_0000, 32'hC000_0000, 1, 1, 0));
        queue_corner(make_corner(24'h000022, 100, -100, 7, 0, 1));
        // negative tiny determinant
        queue_corner(make_corner(24'h000030, 0, 0, 0, 0, 0));
        queue_corner(make_corner(24'h000031, 32'h4000_0000, -5 * ONE, 3, 1, 0));
        queue_corner(make_corner(24'h000032, 9, 32'h7000_0000, 0, 0, -1));
        // edge and uv deltas saturate
        queue_corner(make_corner(24'h123456, QMIN, QMAX, 0, QMIN, QMAX));
        queue_corner(make_corner(24'h654321, QMAX, QMIN, 32'hFFFF_FFFF, QMAX, QMIN));
        queue_corner(make_corner(24'h0F0F0F, QMIN, QMIN, QMAX, QMAX, QMAX));
        // extremes in most fields, alternating bit patterns in z
        queue_corner(make_corner(24'hAAAAAA, QMAX, QMIN, 32'hAAAA_AAAA, QMAX, QMIN));
        queue_corner(make_corner(24'h555555, QMIN, QMAX, 32'h5555_5555, QMIN, QMIN));
        queue_corner(make_corner(24'hFFFFFF, 32'hFFFF_FFFF, 0, QMIN, QMAX, QMAX));
        // collinear uv, zero determinant
        queue_corner(make_corner(24'h000040, 0, 0, 0, ONE, ONE));
        queue_corner(make_corner(24'h000041, 3 * ONE, ONE, 0, 2 * ONE, 3 * ONE));
        queue_corner(make_corner(24'h000042, 0, 2 * ONE, ONE, 3 * ONE, 5 * ONE));
        // random triangles, mostly well-conditioned
        for (int t = 0; t < RAND_TRIANGLES; t++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: queue_random_triangle(TRI_SMALL);
                10, 11, 12, 13:               queue_random_triangle(TRI_FULL);
                14, 15, 16:                   queue_random_triangle(TRI_DEGEN);
                default:                      queue_random_triangle(TRI_MIXED);
            endcase
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (corner_queue.size() != 0 || corner_valid)
            @(posedge clk);
        while (tangent_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && tangent_expect.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
